// File: src/aho_corasick_keyword_counter_defines.svh
// Assertion macros for the keyword counter RTL.
`ifndef AHO_CORASICK_KEYWORD_COUNTER_DEFINES_SVH
`define AHO_CORASICK_KEYWORD_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge outside reset.
`define ACK_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define ACK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ACK_ASSERT(lbl, cond, msg)
`define ACK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/ack_pkg.sv
// Types and codes shared by the keyword counter.
`timescale 1ns / 1ps
package ack_pkg;

    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_PATTERN = 2'd1;
    localparam logic [1:0] REQ_BUILD   = 2'd2;
    localparam logic [1:0] REQ_TEXT    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_NOBUILD  = 2'd2;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] letter;
        logic       last;
    } t_ack_req;

    typedef struct packed {
        logic [15:0] match_count;
        logic [1:0]  status;
    } t_ack_res;

endpackage

// File: src/aho_corasick_keyword_counter.sv
// Top level of the Aho-Corasick keyword counter: control sequencer and memories.
`timescale 1ns / 1ps
`include "aho_corasick_keyword_counter_defines.svh"
// Usage:
//   Requests enter on i_req with start; a transfer happens on a clock edge
//   with start high and busy low. Request kinds: clear dictionary, pattern
//   letter, build links, text letter.
//   A text letter marked last produces one result on o_res, flagged by o_done
//   for exactly one cycle; the receiver cannot stall, so it must sample then.
//   Request steps, from the accepting edge until busy drops:
//     clear         sweep the root row to zero
//     pattern       read the child slot; a newly allocated trie node has its
//                   child row swept to zero; a stored last letter bumps its count
//     build         read and write each letter slot of every trie node, fetching
//                   each non-root node from the breadth-first queue
//     text letter   child read, then chain walk; skipped if out of range or unbuilt
//   The child table has one port pair, so every transition needs its own read
//   of it; the output chain walk reads counts and failure links in parallel.
//   Reset (synchronous, active low) clears the control state and then runs
//   a pass that zeroes the root row; busy is high during it. Rows of later
//   nodes are zeroed when the node is allocated, so no full sweep of the
//   child table is needed. The result is registered at the request's final step.
module aho_corasick_keyword_counter
    import ack_pkg::*;
#(
    parameter int MAX_NODES = 4096,
    parameter int ALPHABET  = 26
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_ack_req i_req,
    output logic     busy,
    output logic     o_done,
    output t_ack_res o_res
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CAW = $clog2(MAX_NODES * ALPHABET);
    localparam int CW  = $clog2(ALPHABET);
    localparam logic [CAW-1:0] ALPHA_C    = CAW'(ALPHABET);
    localparam logic [6:0]     ALPHA7     = 7'(ALPHABET);
    localparam logic [CW-1:0]  ALPHA_LAST = CW'(ALPHABET - 1);
    localparam logic [NW:0]    NC_MAX     = (NW+1)'(MAX_NODES);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DO,
        S_PAT_RD, S_PAT_NEW, S_PAT_END, S_PAT_CNT,
        S_B_RDU, S_B_RDF, S_B_WR, S_B_NEXT, S_B_Q, S_B_F,
        S_T_RD, S_T_CH
    } t_state;

    // control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [NW:0]     r_ncount, n_ncount;
    logic [NW-1:0]   r_ins, n_ins;
    logic [NW-1:0]   r_tnode, n_tnode;
    logic [15:0]     r_total, n_total;
    logic            r_built, n_built;
    logic            r_ovf, n_ovf;
    logic            r_drop, n_drop;
    logic            r_terr, n_terr;
    logic            r_root, n_root;
    logic [NW-1:0]   r_head, n_head;
    logic [NW-1:0]   r_tail, n_tail;
    logic            r_done, n_done;
    // payload
    t_ack_req        r_req, n_req;
    logic [NW-1:0]   r_u, n_u;
    logic [NW-1:0]   r_f, n_f;
    logic [NW-1:0]   r_v, n_v;
    logic [NW-1:0]   r_k, n_k;
    t_ack_res        r_res, n_res;

    // memory ports
    logic            c_we, f_we, e_we, q_we;
    logic [CAW-1:0]  c_waddr, c_raddr;
    logic [NW-1:0]   c_wdata, c_rdata;
    logic [NW-1:0]   f_waddr, f_raddr, f_wdata, f_rdata;
    logic [NW-1:0]   e_waddr, e_raddr;
    logic [15:0]     e_wdata, e_rdata;
    logic [NW-1:0]   q_waddr, q_raddr, q_wdata, q_rdata;

    logic            fin;
    logic [16:0]     sum;
    logic [6:0]      let7;
    logic            let_ok;

    function automatic logic [CAW-1:0] f_slot(logic [NW-1:0] n, logic [6:0] c);
        return CAW'(n) * ALPHA_C + CAW'(c);
    endfunction

    ack_ram #(.WIDTH(NW), .DEPTH(MAX_NODES * ALPHABET)) u_child (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );
    ack_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );
    ack_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_end (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );
    ack_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    assign let7   = {2'b00, r_req.letter};
    assign let_ok = (let7 < ALPHA7);
    // running total plus the count read on the current chain node
    assign sum    = {1'b0, r_total} + {1'b0, e_rdata};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ncount = r_ncount;
        n_ins    = r_ins;
        n_tnode  = r_tnode;
        n_total  = r_total;
        n_built  = r_built;
        n_ovf    = r_ovf;
        n_drop   = r_drop;
        n_terr   = r_terr;
        n_root   = r_root;
        n_head   = r_head;
        n_tail   = r_tail;
        n_done   = 1'b0;
        n_req    = r_req;
        n_u      = r_u;
        n_f      = r_f;
        n_v      = r_v;
        n_k      = r_k;
        n_res    = r_res;
        fin      = 1'b0;
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

        case (r_state)
            S_CLR: begin
                // zero the root row, one entry per cycle
                c_we    = 1'b1;
                c_waddr = CAW'(r_cnt);
                if (r_cnt == '0) begin
                    e_we = 1'b1;
                end
                if (r_cnt == ALPHA_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = S_DO;
                end
            end
            S_DO: begin
                case (r_req.req_type)
                    REQ_CLEAR: begin
                        n_ncount = (NW+1)'(1);
                        n_ins    = '0;
                        n_tnode  = '0;
                        n_total  = '0;
                        n_built  = 1'b0;
                        n_ovf    = 1'b0;
                        n_drop   = 1'b0;
                        n_terr   = 1'b0;
                        n_cnt    = '0;
                        n_state  = S_CLR;
                    end
                    REQ_PATTERN: begin
                        if (r_built) begin
                            n_state = S_IDLE;
                        end else if (!r_drop && let_ok) begin
                            c_raddr = f_slot(r_ins, let7);
                            n_state = S_PAT_RD;
                        end else begin
                            if (!let_ok) begin
                                n_drop = 1'b1;
                            end
                            n_state = S_PAT_END;
                        end
                    end
                    REQ_BUILD: begin
                        if (r_built) begin
                            n_state = S_IDLE;
                        end else begin
                            f_we    = 1'b1;
                            n_u     = '0;
                            n_f     = '0;
                            n_root  = 1'b1;
                            n_cnt   = '0;
                            n_head  = '0;
                            n_tail  = '0;
                            n_state = S_B_RDU;
                        end
                    end
                    default: begin
                        if (!r_built) begin
                            n_terr = 1'b1;
                            fin    = 1'b1;
                        end else if (!let_ok) begin
                            n_tnode = '0;
                            fin     = 1'b1;
                        end else begin
                            c_raddr = f_slot(r_tnode, let7);
                            n_state = S_T_RD;
                        end
                    end
                endcase
            end
            S_PAT_RD: begin
                if (c_rdata == '0) begin
                    if (r_ncount == NC_MAX) begin
                        n_ovf   = 1'b1;
                        n_drop  = 1'b1;
                        n_state = S_PAT_END;
                    end else begin
                        c_we     = 1'b1;
                        c_waddr  = f_slot(r_ins, let7);
                        c_wdata  = r_ncount[NW-1:0];
                        n_ins    = r_ncount[NW-1:0];
                        n_ncount = r_ncount + 1'b1;
                        n_cnt    = '0;
                        n_state  = S_PAT_NEW;
                    end
                end else begin
                    n_ins   = c_rdata;
                    n_state = S_PAT_END;
                end
            end
            S_PAT_NEW: begin
                // fresh node: sweep its row and count to zero
                c_we    = 1'b1;
                c_waddr = f_slot(r_ins, 7'(r_cnt));
                if (r_cnt == '0) begin
                    e_we    = 1'b1;
                    e_waddr = r_ins;
                end
                if (r_cnt == ALPHA_LAST) begin
                    n_cnt   = '0;
                    n_state = S_PAT_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_PAT_END: begin
                n_state = S_IDLE;
                if (r_req.last) begin
                    if (!r_drop) begin
                        e_raddr = r_ins;
                        n_state = S_PAT_CNT;
                    end else begin
                        n_ins  = '0;
                        n_drop = 1'b0;
                    end
                end
            end
            S_PAT_CNT: begin
                e_we    = 1'b1;
                e_waddr = r_ins;
                e_wdata = (e_rdata == SAT16) ? e_rdata : e_rdata + 16'd1;
                n_ins   = '0;
                n_drop  = 1'b0;
                n_state = S_IDLE;
            end
            S_B_RDU: begin
                c_raddr = f_slot(r_u, 7'(r_cnt));
                n_state = S_B_RDF;
            end
            S_B_RDF: begin
                n_v     = c_rdata;
                c_raddr = f_slot(r_f, 7'(r_cnt));
                n_state = S_B_WR;
            end
            S_B_WR: begin
                if (r_v != '0) begin
                    f_we    = 1'b1;
                    f_waddr = r_v;
                    f_wdata = r_root ? '0 : c_rdata;
                    q_we    = 1'b1;
                    q_waddr = r_tail;
                    q_wdata = r_v;
                    n_tail  = r_tail + 1'b1;
                end else if (!r_root) begin
                    c_we    = 1'b1;
                    c_waddr = f_slot(r_u, 7'(r_cnt));
                    c_wdata = c_rdata;
                end
                if (r_cnt == ALPHA_LAST) begin
                    n_cnt   = '0;
                    n_state = S_B_NEXT;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_B_RDU;
                end
            end
            S_B_NEXT: begin
                if (r_head == r_tail) begin
                    n_built = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    q_raddr = r_head;
                    n_head  = r_head + 1'b1;
                    n_state = S_B_Q;
                end
            end
            S_B_Q: begin
                n_u     = q_rdata;
                f_raddr = q_rdata;
                n_state = S_B_F;
            end
            S_B_F: begin
                n_f     = f_rdata;
                n_root  = 1'b0;
                n_state = S_B_RDU;
            end
            S_T_RD: begin
                n_tnode = c_rdata;
                if (c_rdata == '0) begin
                    fin = 1'b1;
                end else begin
                    e_raddr = c_rdata;
                    f_raddr = c_rdata;
                    n_k     = c_rdata;
                    n_state = S_T_CH;
                end
            end
            S_T_CH: begin
                // one chain node per cycle: count and link arrive together
                n_total = sum[16] ? SAT16 : sum[15:0];
                e_we    = 1'b1;
                e_waddr = r_k;
                if (f_rdata == '0) begin
                    fin = 1'b1;
                end else begin
                    e_raddr = f_rdata;
                    f_raddr = f_rdata;
                    n_k     = f_rdata;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
            if (r_req.last) begin
                n_done            = 1'b1;
                n_res.match_count = n_total;
                n_res.status      = n_terr ? ST_NOBUILD : (n_ovf ? ST_OVERFLOW : ST_OK);
                n_total           = '0;
                n_tnode           = '0;
                n_terr            = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_ncount <= (NW+1)'(1);
            r_ins    <= '0;
            r_tnode  <= '0;
            r_total  <= '0;
            r_built  <= 1'b0;
            r_ovf    <= 1'b0;
            r_drop   <= 1'b0;
            r_terr   <= 1'b0;
            r_root   <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ncount <= n_ncount;
            r_ins    <= n_ins;
            r_tnode  <= n_tnode;
            r_total  <= n_total;
            r_built  <= n_built;
            r_ovf    <= n_ovf;
            r_drop   <= n_drop;
            r_terr   <= n_terr;
            r_root   <= n_root;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_done   <= n_done;
        end
        r_req <= n_req;
        r_u   <= n_u;
        r_f   <= n_f;
        r_v   <= n_v;
        r_k   <= n_k;
        r_res <= n_res;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    `ACK_ASSERT(a_ncount_max, r_ncount <= NC_MAX, "node count beyond capacity")
    `ACK_ASSERT(a_ins_alloc, {1'b0, r_ins} < r_ncount, "insert node not allocated")
    `ACK_ASSERT(a_queue_order, r_head <= r_tail, "queue head passed tail")
    `ACK_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "result strobe longer than one cycle")
    `ACK_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

endmodule

// File: src/ack_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ack_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sim/aho_corasick_keyword_counter_tb.sv
// Self-checking testbench for the Aho-Corasick keyword counter.
`timescale 1ns / 1ps
module aho_corasick_keyword_counter_tb;
    import ack_pkg::*;

    localparam int NODES = 4096;
    localparam int ALPHA = 26;
    localparam longint CYCLE_LIMIT = 6000000;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_ack_req i_req;
    logic     busy;
    logic     o_done;
    t_ack_res o_res;

    aho_corasick_keyword_counter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Shadow automaton, kept in step with every accepted transfer.
    int       goto_tbl [NODES*ALPHA];
    int       fail_tbl [NODES];
    int       kw_count [NODES];
    int       walk_q   [NODES];
    int       n_nodes;
    int       ins_node;
    int       txt_node;
    int       hit_total;
    bit       is_built;
    bit       dict_ovf;
    bit       pat_drop;
    bit       txt_err;

    t_ack_res count_q[$];
    int       n_fail;
    int       idle_pct;
    longint   cycles;

    function automatic void dict_clear();
        for (int n = 0; n < n_nodes; n++) begin
            for (int c = 0; c < ALPHA; c++) goto_tbl[n*ALPHA+c] = 0;
            fail_tbl[n] = 0;
            kw_count[n] = 0;
        end
        n_nodes = 1; ins_node = 0; txt_node = 0; hit_total = 0;
        is_built = 0; dict_ovf = 0; pat_drop = 0; txt_err = 0;
    endfunction

    function automatic void add_letter(int c, bit lst);
        int s;
        if (is_built) return;
        if (!pat_drop) begin
            if (c >= ALPHA) begin
                pat_drop = 1;
            end else begin
                s = ins_node*ALPHA + c;
                if (goto_tbl[s] == 0) begin
                    if (n_nodes >= NODES) begin
                        dict_ovf = 1;
                        pat_drop = 1;
                    end else begin
                        goto_tbl[s] = n_nodes;
                        n_nodes++;
                    end
                end
                if (!pat_drop) ins_node = goto_tbl[s];
            end
        end
        if (lst) begin
            if (!pat_drop && kw_count[ins_node] < 65535) kw_count[ins_node]++;
            ins_node = 0;
            pat_drop = 0;
        end
    endfunction

    function automatic void link_build();
        int head, tail, u, f, v;
        if (is_built) return;
        head = 0; tail = 0;
        fail_tbl[0] = 0;
        for (int c = 0; c < ALPHA; c++) begin
            v = goto_tbl[c];
            if (v != 0) begin
                fail_tbl[v] = 0;
                walk_q[tail++] = v;
            end
        end
        while (head < tail) begin
            u = walk_q[head++];
            f = fail_tbl[u];
            for (int c = 0; c < ALPHA; c++) begin
                v = goto_tbl[u*ALPHA+c];
                if (v != 0) begin
                    fail_tbl[v] = goto_tbl[f*ALPHA+c];
                    if (tail < NODES) walk_q[tail++] = v;
                end else begin
                    goto_tbl[u*ALPHA+c] = goto_tbl[f*ALPHA+c];
                end
            end
        end
        is_built = 1;
    endfunction

    function automatic void scan_letter(int c, bit lst);
        int k;
        t_ack_res r;
        if (!is_built) begin
            txt_err = 1;
        end else if (c >= ALPHA) begin
            txt_node = 0;
        end else begin
            txt_node = goto_tbl[txt_node*ALPHA+c];
            k = txt_node;
            for (int g = 0; k != 0 && g < NODES; g++) begin
                hit_total += kw_count[k];
                if (hit_total > 65535) hit_total = 65535;
                kw_count[k] = 0;
                k = fail_tbl[k];
            end
        end
        if (lst) begin
            r.match_count = hit_total[15:0];
            r.status = txt_err ? ST_NOBUILD : (dict_ovf ? ST_OVERFLOW : ST_OK);
            count_q.push_back(r);
            hit_total = 0; txt_node = 0; txt_err = 0;
        end
    endfunction

    // One transfer: hold start until busy is low at a rising edge.
    task automatic send_req(logic [1:0] kind, int c, bit lst);
        int gap;
        @(negedge i_clk);
        start = 1'b1;
        i_req.req_type = kind;
        i_req.letter = c[4:0];
        i_req.last = lst;
        do @(posedge i_clk); while (busy);
        case (kind)
            REQ_CLEAR:   dict_clear();
            REQ_PATTERN: add_letter(c, lst);
            REQ_BUILD:   link_build();
            default:     scan_letter(c, lst);
        endcase
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            start = 1'b0;
            i_req = t_ack_req'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_word(logic [1:0] kind, string w);
        for (int i = 0; i < w.len(); i++) send_req(kind, w[i] - "a", i == w.len() - 1);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        wait (count_q.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Result checker: o_done is a one-cycle strobe.
    always @(posedge i_clk) begin
        t_ack_res want;
        if (i_rst_n && o_done) begin
            if (count_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result: got %0d/%0d",
                                           o_res.match_count, o_res.status);
            end else begin
                want = count_q.pop_front();
                if (o_res.match_count !== want.match_count || o_res.status !== want.status) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: count exp %0d got %0d, status exp %0d got %0d",
                                 want.match_count, o_res.match_count, want.status, o_res.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Classic dictionary, error cases, odd letters.
    task automatic test_directed();
        send_req(REQ_TEXT, 3, 1);             // text before build
        send_word(REQ_PATTERN, "he");
        send_word(REQ_PATTERN, "she");
        send_word(REQ_PATTERN, "his");
        send_word(REQ_PATTERN, "hers");
        send_req(REQ_PATTERN, 31, 0);         // out of range drops the pattern
        send_req(REQ_PATTERN, 0, 1);
        send_req(REQ_TEXT, 25, 1);            // text before build
        send_req(REQ_BUILD, 0, 0);
        send_req(REQ_BUILD, 21, 1);           // second build ignored
        send_word(REQ_PATTERN, "zz");         // ignored after build
        send_word(REQ_TEXT, "ushers");
        send_word(REQ_TEXT, "she");           // counts already consumed
        send_req(REQ_TEXT, 26, 0);            // out of range back to root
        send_req(REQ_TEXT, 7, 0);
        send_req(REQ_TEXT, 30, 1);
        send_req(REQ_CLEAR, 0, 0);
        send_word(REQ_PATTERN, "z");
        send_req(REQ_BUILD, 0, 0);
        send_word(REQ_TEXT, "zaz");
        drain();
    endtask

    // Store one keyword many times; its count adds up once.
    task automatic test_repeat();
        send_req(REQ_CLEAR, 0, 0);
        for (int i = 0; i < 40; i++) send_req(REQ_PATTERN, 1, 1);
        send_req(REQ_BUILD, 0, 0);
        send_word(REQ_TEXT, "bb");
        drain();
    endtask

    // Well-formed sessions over a small alphabet, with some noise.
    task automatic test_random(int n_items);
        int sent, len, alpha;
        sent = 0;
        while (sent < n_items) begin
            alpha = $urandom_range(2, 6);
            send_req(REQ_CLEAR, $urandom_range(31), $urandom_range(1));
            sent++;
            repeat ($urandom_range(1, 8)) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    send_req(REQ_PATTERN, ($urandom_range(99) < 3) ? $urandom_range(31)
                             : $urandom_range(alpha - 1), i == len - 1);
                    sent++;
                end
            end
            if ($urandom_range(9) != 0) send_req(REQ_BUILD, $urandom_range(31), $urandom_range(1));
            sent++;
            repeat ($urandom_range(1, 5)) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < 4)
                        send_req(2'($urandom_range(2)), $urandom_range(31), $urandom_range(1));
                    send_req(REQ_TEXT, ($urandom_range(99) < 3) ? $urandom_range(31)
                             : $urandom_range(alpha - 1), i == len - 1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        n_fail = 0; cycles = 0; idle_pct = 12;
        n_nodes = NODES;
        dict_clear();
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(450);
        drain();
        idle_pct = 55;
        test_random(450);
        idle_pct = 0;
        test_random(450);
        test_repeat();

        drain();
        repeat (200) @(posedge i_clk);
        if (n_fail == 0 && count_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
